/* hdl/tea_pkg.sv */
// ----------------------------------------------------------------------------
// TEA package
// Shared types and constants for the pipelined TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

	// Golden-ratio round constant
	localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

	// Operation codes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// Key register indexes
	localparam logic [1:0] KEY_IDX_0 = 2'd0;
	localparam logic [1:0] KEY_IDX_1 = 2'd1;
	localparam logic [1:0] KEY_IDX_2 = 2'd2;
	localparam logic [1:0] KEY_IDX_3 = 2'd3;

	// Input transaction: opcode and 64-bit block
	typedef struct packed {
		logic        opcode;
		logic [31:0] block_word_0;
		logic [31:0] block_word_1;
	} in_item_t;

	// Output transaction: transformed block
	typedef struct packed {
		logic [31:0] result_word_0;
		logic [31:0] result_word_1;
	} out_item_t;

	// 128-bit key as four words
	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} tea_key_t;

endpackage

/* hdl/tea_round_cell.sv */
// ----------------------------------------------------------------------------
// TEA half-round cell
// One Feistel half-round: updates one block word from the other, encrypt or
// decrypt according to the opcode carried with the block.
// ----------------------------------------------------------------------------
module tea_round_cell #(
	parameter logic [31:0] SUM_ENC    = 32'h9e37_79b9,
	parameter logic [31:0] SUM_DEC    = 32'h9e37_79b9,
	parameter bit          FIRST_HALF = 1'b1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              valid_in,
	input  tea_pkg::in_item_t data_in,
	input  tea_pkg::tea_key_t key,
	output logic              valid,
	output tea_pkg::in_item_t data
);

	logic              valid_q;
	tea_pkg::in_item_t data_q;
	tea_pkg::in_item_t data_nxt;
	logic              is_enc;
	logic              upd_w0;
	logic [31:0]       x;
	logic [31:0]       tgt;
	logic [31:0]       ka;
	logic [31:0]       kb;
	logic [31:0]       sum;
	logic [31:0]       mix;
	logic [31:0]       upd;

	// Select source word, target word, keys and sum for this half-round
	always_comb begin
		is_enc = (data_in.opcode == tea_pkg::OP_ENCRYPT);
		upd_w0 = is_enc ? FIRST_HALF : !FIRST_HALF;
		x      = upd_w0 ? data_in.block_word_1 : data_in.block_word_0;
		tgt    = upd_w0 ? data_in.block_word_0 : data_in.block_word_1;
		ka     = upd_w0 ? key.k0 : key.k2;
		kb     = upd_w0 ? key.k1 : key.k3;
		sum    = is_enc ? SUM_ENC : SUM_DEC;
	end

	// Mix and fold into the target word
	always_comb begin
		mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
		upd = is_enc ? (tgt + mix) : (tgt - mix);
		data_nxt              = data_in;
		data_nxt.block_word_0 = upd_w0 ? upd : data_in.block_word_0;
		data_nxt.block_word_1 = upd_w0 ? data_in.block_word_1 : upd;
	end

	// Valid bit of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	// Block data of the stage
	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= data_nxt;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

/* hdl/tea_block_cipher.sv */
// ----------------------------------------------------------------------------
// TEA block cipher
// Pipelined TEA encrypt/decrypt: a chain of 2*ROUNDS half-round cells,
// one 64-bit block accepted per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Transfer
//  -------   -------------------------------  ---------------------------
//  blk       blk_valid, blk_ready, blk_data   input block and opcode
//  res       res_valid, res_ready, res_data   transformed block
//  cfg       cfg_we, cfg_index, cfg_data      key word write, no wait
//
//  Throughput: one block per cycle; the chain of half-round cells moves
//  every cycle that the result is not stalled.
//  Each of the 2*ROUNDS half-round cells is registered, one per half-round.
//  Reset clears the key words and every stage valid bit.
//  A stall on res freezes the whole chain; blk_ready drops with it.
//
module tea_block_cipher #(
	parameter int ROUNDS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               blk_valid,
	output logic               blk_ready,
	input  tea_pkg::in_item_t  blk_data,
	output logic               res_valid,
	input  logic               res_ready,
	output tea_pkg::out_item_t res_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int NumCells = 2 * ROUNDS;

	tea_pkg::tea_key_t key_q;
	logic              advance;
	logic              cell_valid [0:NumCells];
	tea_pkg::in_item_t cell_data  [0:NumCells];

	// Write key words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tea_pkg::KEY_IDX_0: key_q.k0 <= cfg_data;
				tea_pkg::KEY_IDX_1: key_q.k1 <= cfg_data;
				tea_pkg::KEY_IDX_2: key_q.k2 <= cfg_data;
				tea_pkg::KEY_IDX_3: key_q.k3 <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the chain unless a finished result is held
	assign advance   = !res_valid || res_ready;
	assign blk_ready = advance;

	assign cell_valid[0] = blk_valid;
	assign cell_data[0]  = blk_data;

	// Chain of half-round cells
	for (genvar c = 0; c < NumCells; c++) begin : g_cell
		localparam int          Rnd    = c / 2;
		localparam logic [31:0] SumEnc = 32'(tea_pkg::TEA_DELTA * (Rnd + 1));
		localparam logic [31:0] SumDec = 32'(tea_pkg::TEA_DELTA * (ROUNDS - Rnd));

		tea_round_cell #(
			.SUM_ENC    (SumEnc),
			.SUM_DEC    (SumDec),
			.FIRST_HALF ((c % 2) == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.valid_in (cell_valid[c]),
			.data_in  (cell_data[c]),
			.key      (key_q),
			.valid    (cell_valid[c+1]),
			.data     (cell_data[c+1])
		);
	end

	// Drive the result from the last cell
	assign res_valid              = cell_valid[NumCells];
	assign res_data.result_word_0 = cell_data[NumCells].block_word_0;
	assign res_data.result_word_1 = cell_data[NumCells].block_word_1;

	// An accepted transaction occupies the first cell next cycle
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && blk_ready |=> g_cell[0].u_cell.valid)
		else $error("accepted block did not enter first cell");

	// A held result blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !blk_ready)
		else $error("input accepted while result stalled");

	// A key write to word 0 lands in that word
	a_key_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == tea_pkg::KEY_IDX_0) |=> key_q.k0 == $past(cfg_data))
		else $error("key word 0 not written");

endmodule

/* test/tea_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TEA block checker
// Watches the key write port and both block channels. It predicts each
// transformed block with its own copy of the key, queues the prediction and
// compares every result transaction field by field against the oldest one.
// ----------------------------------------------------------------------------
module tea_checker #(
	parameter int ROUNDS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               blk_valid,
	input  logic               blk_ready,
	input  tea_pkg::in_item_t  blk_data,
	input  logic               res_valid,
	input  logic               res_ready,
	input  tea_pkg::out_item_t res_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 mismatches,
	output int                 pending
);

	tea_pkg::tea_key_t  key_copy;
	tea_pkg::out_item_t expected_blocks[$];
	int                 fail_count;

	// Feistel mix of one half with the running sum and a key pair
	function automatic logic [31:0] feistel_mix(logic [31:0] x, logic [31:0] sum,
			logic [31:0] ka, logic [31:0] kb);
		return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	endfunction

	// Run the full cipher on one block under the given key
	function automatic tea_pkg::out_item_t tea_transform(tea_pkg::in_item_t blk,
			tea_pkg::tea_key_t k);
		logic [31:0]        v0;
		logic [31:0]        v1;
		logic [31:0]        sum;
		tea_pkg::out_item_t res;
		v0 = blk.block_word_0;
		v1 = blk.block_word_1;
		if (blk.opcode == tea_pkg::OP_ENCRYPT) begin
			sum = '0;
			for (int rnd = 0; rnd < ROUNDS; rnd++) begin
				sum = sum + tea_pkg::TEA_DELTA;
				v0  = v0 + feistel_mix(v1, sum, k.k0, k.k1);
				v1  = v1 + feistel_mix(v0, sum, k.k2, k.k3);
			end
		end else begin
			sum = tea_pkg::TEA_DELTA * 32'(ROUNDS);
			for (int rnd = 0; rnd < ROUNDS; rnd++) begin
				v1  = v1 - feistel_mix(v0, sum, k.k2, k.k3);
				v0  = v0 - feistel_mix(v1, sum, k.k0, k.k1);
				sum = sum - tea_pkg::TEA_DELTA;
			end
		end
		res.result_word_0 = v0;
		res.result_word_1 = v1;
		return res;
	endfunction

	// Print one line per mismatch and count every one
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	// Predict on block transactions, compare on result transactions, track key writes
	always @(posedge clk or negedge arst_n) begin
		tea_pkg::out_item_t want;
		if (!arst_n) begin
			key_copy = '0;
			expected_blocks.delete();
			fail_count = 0;
		end else begin
			if (blk_valid && blk_ready)
				expected_blocks.push_back(tea_transform(blk_data, key_copy));
			if (res_valid && res_ready) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch("result with no block pending", res_data.result_word_0, '0);
				end else begin
					want = expected_blocks.pop_front();
					if (res_data.result_word_0 !== want.result_word_0)
						report_mismatch("result_word_0", res_data.result_word_0,
							want.result_word_0);
					if (res_data.result_word_1 !== want.result_word_1)
						report_mismatch("result_word_1", res_data.result_word_1,
							want.result_word_1);
				end
			end
			// Apply key writes after prediction, as the block does
			if (cfg_we) begin
				case (cfg_index)
					tea_pkg::KEY_IDX_0: key_copy.k0 = cfg_data;
					tea_pkg::KEY_IDX_1: key_copy.k1 = cfg_data;
					tea_pkg::KEY_IDX_2: key_copy.k2 = cfg_data;
					tea_pkg::KEY_IDX_3: key_copy.k3 = cfg_data;
					default: ;
				endcase
			end
		end
		mismatches <= fail_count;
		pending    <= expected_blocks.size();
	end

endmodule

/* test/tb_tea_block_cipher.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TEA block cipher testbench
// Drives directed and random blocks through the cipher under several keys,
// with random idle bursts on both channels, and leaves checking to the
// checker instance. Gives the verdict from its mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_tea_block_cipher;

	localparam int ROUNDS     = 32;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_SIZE = 120;

	logic               clk;
	logic               arst_n;
	logic               blk_valid;
	logic               blk_ready;
	tea_pkg::in_item_t  blk_data;
	logic               res_valid;
	logic               res_ready;
	tea_pkg::out_item_t res_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int        mismatches;
	int        pending;

	logic      quiet;
	logic      tx_calm;
	int        stall_left;
	logic      rx_calm;
	int        idle_cycles;

	tea_block_cipher #(.ROUNDS(ROUNDS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk_data  (blk_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tea_checker #(.ROUNDS(ROUNDS)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_valid  (blk_valid),
		.blk_ready  (blk_ready),
		.blk_data   (blk_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the result channel in random bursts, with calm stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			rx_calm    = 1'b0;
			stall_left = 0;
		end else if (quiet) begin
			res_ready <= 1'b1;
		end else begin
			if ($urandom_range(0, 63) == 0)
				rx_calm = ~rx_calm;
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// End the run when no transaction has been accepted for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((blk_valid && blk_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_tea_block_cipher NOT OK");
				$finish;
			end
		end
	end

	// Write one key register
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Load all four key words while the block is idle
	task automatic load_key(tea_pkg::tea_key_t k);
		write_reg(tea_pkg::KEY_IDX_0, k.k0);
		write_reg(tea_pkg::KEY_IDX_1, k.k1);
		write_reg(tea_pkg::KEY_IDX_2, k.k2);
		write_reg(tea_pkg::KEY_IDX_3, k.k3);
		cfg_we <= 1'b0;
	endtask

	// Hold off the sender until every predicted block has come back
	task automatic wait_drained();
		blk_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Offer one block transaction, after an optional idle burst
	task automatic send_block(logic op, logic [31:0] w0, logic [31:0] w1);
		int gap;
		if ($urandom_range(0, 31) == 0)
			tx_calm = ~tx_calm;
		gap = (!quiet && !tx_calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			blk_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blk_valid              <= 1'b1;
		blk_data.opcode        <= op;
		blk_data.block_word_0  <= w0;
		blk_data.block_word_1  <= w1;
		do @(posedge clk); while (!blk_ready);
	endtask

	// Pick a word, now and then an extreme or single-bit pattern
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return '1;
			2:       return 32'h1 << $urandom_range(0, 31);
			3:       return ~(32'h1 << $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	function automatic tea_pkg::tea_key_t random_key();
		tea_pkg::tea_key_t k;
		k.k0 = random_word();
		k.k1 = random_word();
		k.k2 = random_word();
		k.k3 = random_word();
		return k;
	endfunction

	// Send a run of random blocks, both operations mixed
	task automatic random_blocks(int count);
		for (int n = 0; n < count; n++)
			send_block($urandom_range(0, 1) ? tea_pkg::OP_DECRYPT : tea_pkg::OP_ENCRYPT,
				random_word(), random_word());
	endtask

	// Main sequence: reset, directed blocks, then keyed random phases
	initial begin
		logic [31:0] patterns[6];
		patterns = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
			32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555};
		arst_n      <= 1'b0;
		blk_valid   <= 1'b0;
		blk_data    <= '0;
		cfg_we      <= 1'b0;
		cfg_index   <= tea_pkg::KEY_IDX_0;
		cfg_data    <= '0;
		quiet       <= 1'b0;
		tx_calm     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed blocks under the all-zero reset key
		foreach (patterns[i]) begin
			send_block(tea_pkg::OP_ENCRYPT, patterns[i], patterns[i]);
			send_block(tea_pkg::OP_DECRYPT, patterns[i], patterns[i]);
			send_block(tea_pkg::OP_ENCRYPT, patterns[i], ~patterns[i]);
			send_block(tea_pkg::OP_DECRYPT, patterns[i], ~patterns[i]);
		end
		wait_drained();

		// All-ones key
		load_key('1);
		random_blocks(PHASE_SIZE);
		wait_drained();

		// Random key, with a full drain in the middle of the phase
		load_key(random_key());
		random_blocks(PHASE_SIZE / 2);
		wait_drained();
		random_blocks(PHASE_SIZE / 2);
		wait_drained();

		// Fixed textbook-style key, then back to zero written explicitly
		load_key({32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210});
		random_blocks(PHASE_SIZE);
		wait_drained();
		load_key('0);
		random_blocks(PHASE_SIZE / 2);
		wait_drained();

		// Last part: random key, no idling on either side
		quiet <= 1'b1;
		load_key(random_key());
		random_blocks(PHASE_SIZE + PHASE_SIZE / 2);
		blk_valid <= 1'b0;

		// Drain, then let the pipeline run out
		do @(posedge clk); while (pending != 0);
		repeat (2 * ROUNDS + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb_tea_block_cipher OK");
		else
			$display("tb_tea_block_cipher NOT OK");
		$finish;
	end

endmodule

/* files.f */
hdl/tea_pkg.sv
hdl/tea_round_cell.sv
hdl/tea_block_cipher.sv
test/tea_checker.sv
test/tb_tea_block_cipher.sv
